FILE: src/dme_pkg.sv
// ----------------------------------------------------------------------------
// Delimited message extractor package
// Shared widths, register codes, status codes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package dme_pkg;

  // Frame store depth in bytes and derived widths
  localparam int FRAME_DEPTH = 64;
  localparam int ADDR_W      = $clog2(FRAME_DEPTH);
  localparam int CNT_W       = $clog2(FRAME_DEPTH + 1);

  // Field widths
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 7;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Register reset values
  localparam logic [BYTE_W-1:0] START_DELIM_RST    = 8'd123;
  localparam logic [BYTE_W-1:0] END_DELIM_RST      = 8'd125;
  localparam logic [LEN_W-1:0]  MAX_MSG_SIZE_RST   = 7'd65;
  localparam logic              INCLUDE_DELIMS_RST = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_DELIM    = 2'd0,
    CFG_END_DELIM      = 2'd1,
    CFG_MAX_MSG_SIZE   = 2'd2,
    CFG_INCLUDE_DELIMS = 2'd3
  } dme_cfg_idx_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK               = 3'd0,
    ST_FOOTER_NO_HEADER = 3'd1,
    ST_TOO_LARGE        = 3'd2,
    ST_HEADER_NO_FOOTER = 3'd3,
    ST_NO_DELIMS        = 3'd4
  } dme_status_t;

  // Controller states
  typedef enum logic [1:0] {
    S_ACCEPT,
    S_FETCH,
    S_LOAD
  } dme_state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;  // input transfer this cycle
    logic fetch;   // read frame store at the read pointer
    logic load;    // move read data into the output register
  } dme_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
    logic burst;      // current input byte closes a frame with bytes to emit
    logic last_byte;  // one byte left in the current burst
  } dme_stat_t;

endpackage

FILE: src/dme_if.sv
// ----------------------------------------------------------------------------
// Delimited message extractor channels
// Valid/ready channels for received bytes and for extracted results.
// ----------------------------------------------------------------------------
interface dme_in_if;
  logic                       valid;
  logic                       ready;
  logic [dme_pkg::BYTE_W-1:0] in_byte;
  logic                       end_of_buffer;

  modport source (output valid, output in_byte, output end_of_buffer, input ready);
  modport sink (input valid, input in_byte, input end_of_buffer, output ready);
endinterface

interface dme_out_if;
  logic                         valid;
  logic                         ready;
  logic [dme_pkg::BYTE_W-1:0]   data_byte;
  logic                         byte_valid;
  logic                         run_last;
  logic [dme_pkg::STATUS_W-1:0] status;
  logic [dme_pkg::LEN_W-1:0]    msg_length;

  modport source (output valid, output data_byte, output byte_valid, output run_last,
                  output status, output msg_length, input ready);
  modport sink (input valid, input data_byte, input byte_valid, input run_last,
                input status, input msg_length, output ready);
endinterface

FILE: src/dme_ctrl.sv
// ----------------------------------------------------------------------------
// Delimited message extractor controller
// Scans input bytes, then sequences frame emission: one frame store read
// and one output register load per emitted byte.
// ----------------------------------------------------------------------------
module dme_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               rx_valid,
  output logic               rx_ready,
  input  dme_pkg::dme_stat_t stat,
  output dme_pkg::dme_cmd_t  cmd
);
  import dme_pkg::*;

  dme_state_t state;
  dme_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACCEPT;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_ACCEPT: begin
        if (rx_valid && rx_ready && stat.burst) begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (stat.out_free) begin
          state_next = stat.last_byte ? S_ACCEPT : S_FETCH;
        end
      end
      default: begin
        state_next = S_ACCEPT;
      end
    endcase
  end

  // Outputs
  always_comb begin
    rx_ready   = 1'b0;
    cmd.accept = 1'b0;
    cmd.fetch  = 1'b0;
    cmd.load   = 1'b0;
    case (state)
      S_ACCEPT: begin
        rx_ready   = stat.out_free;
        cmd.accept = rx_valid && stat.out_free;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
      end
      S_LOAD: begin
        cmd.load = stat.out_free;
      end
      default: begin
        rx_ready = 1'b0;
      end
    endcase
  end

endmodule

FILE: src/dme_datapath.sv
// ----------------------------------------------------------------------------
// Delimited message extractor datapath
// Configuration registers, frame tracking, frame store and output register.
// ----------------------------------------------------------------------------
module dme_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [dme_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dme_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [dme_pkg::BYTE_W-1:0]     in_byte,
  input  logic                           end_of_buffer,
  input  dme_pkg::dme_cmd_t              cmd,
  output dme_pkg::dme_stat_t             stat,
  input  logic                           tx_ready,
  output logic                           tx_valid,
  output logic [dme_pkg::BYTE_W-1:0]     data_byte,
  output logic                           byte_valid,
  output logic                           run_last,
  output logic [dme_pkg::STATUS_W-1:0]   status,
  output logic [dme_pkg::LEN_W-1:0]      msg_length
);
  import dme_pkg::*;

  // Configuration
  logic [BYTE_W-1:0] start_delim;
  logic [BYTE_W-1:0] end_delim;
  logic [LEN_W-1:0]  max_msg_size;
  logic              include_delims;

  // Frame tracking
  logic [CNT_W-1:0] frame_count;
  logic             start_seen;
  logic             frame_overflow;
  logic             discard_rest;

  // Frame store and burst read side
  logic [BYTE_W-1:0] frame_store [FRAME_DEPTH];
  logic [BYTE_W-1:0] rd_data;
  logic [ADDR_W-1:0] rd_ptr;
  logic [LEN_W-1:0]  remaining;
  logic [LEN_W-1:0]  burst_len;

  // Byte classification
  logic             same;
  logic             active;
  logic             hit_start;
  logic             hit_end;
  logic             do_open;
  logic             do_close;
  logic             do_stray;
  logic             do_append;
  logic             has_room;
  logic [CNT_W-1:0] count_app;
  logic             ovf_app;
  logic [LEN_W-1:0] count_len;
  logic             too_large;
  logic [LEN_W-1:0] emit_len;
  logic             discard_after;
  logic             start_after;
  logic             eob_report;
  logic             status_result;
  dme_status_t      status_code;
  logic             mem_we;
  logic [ADDR_W-1:0] mem_waddr;

  // Classify the current byte against the delimiters
  always_comb begin
    same      = (start_delim == end_delim);
    active    = !discard_rest;
    hit_start = active && (in_byte == start_delim);
    hit_end   = active && (in_byte != start_delim) && (in_byte == end_delim);
    do_close  = (hit_start && same && start_seen) || (hit_end && start_seen);
    do_open   = hit_start && !(same && start_seen);
    do_stray  = hit_end && !start_seen;
    do_append = do_close || do_open || (active && !hit_start && !hit_end && start_seen);
  end

  // Length after appending, size check and emitted length
  always_comb begin
    has_room  = (frame_count < CNT_W'(FRAME_DEPTH));
    count_app = has_room ? frame_count + CNT_W'(1) : frame_count;
    ovf_app   = frame_overflow || !has_room;
    count_len = LEN_W'(count_app);
    too_large = ovf_app || (count_len >= max_msg_size);
    if (include_delims) begin
      emit_len = count_len;
    end else if (count_len >= LEN_W'(2)) begin
      emit_len = count_len - LEN_W'(2);
    end else begin
      emit_len = '0;
    end
  end

  // Pick the single status-only result this byte may cause
  always_comb begin
    discard_after = discard_rest || do_close || do_stray;
    start_after   = start_seen || do_open;
    eob_report    = end_of_buffer && !discard_after;
    status_result = 1'b0;
    status_code   = ST_OK;
    if (do_close && too_large) begin
      status_result = 1'b1;
      status_code   = ST_TOO_LARGE;
    end else if (do_close && (emit_len == '0)) begin
      status_result = 1'b1;
      status_code   = ST_OK;
    end else if (do_stray) begin
      status_result = 1'b1;
      status_code   = ST_FOOTER_NO_HEADER;
    end else if (eob_report) begin
      status_result = 1'b1;
      status_code   = start_after ? ST_HEADER_NO_FOOTER : ST_NO_DELIMS;
    end
  end

  // Status toward the controller
  always_comb begin
    stat.out_free  = !tx_valid || tx_ready;
    stat.burst     = do_close && !too_large && (emit_len != '0);
    stat.last_byte = (remaining == LEN_W'(1));
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_delim    <= START_DELIM_RST;
      end_delim      <= END_DELIM_RST;
      max_msg_size   <= MAX_MSG_SIZE_RST;
      include_delims <= INCLUDE_DELIMS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_START_DELIM:    start_delim    <= cfg_data[BYTE_W-1:0];
        CFG_END_DELIM:      end_delim      <= cfg_data[BYTE_W-1:0];
        CFG_MAX_MSG_SIZE:   max_msg_size   <= cfg_data[LEN_W-1:0];
        CFG_INCLUDE_DELIMS: include_delims <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Frame tracking; clear everything at the end of a buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count    <= '0;
      start_seen     <= 1'b0;
      frame_overflow <= 1'b0;
      discard_rest   <= 1'b0;
    end else if (cmd.accept) begin
      if (end_of_buffer) begin
        frame_count    <= '0;
        start_seen     <= 1'b0;
        frame_overflow <= 1'b0;
        discard_rest   <= 1'b0;
      end else begin
        discard_rest <= discard_after;
        if (do_open) begin
          frame_count    <= CNT_W'(1);
          frame_overflow <= 1'b0;
          start_seen     <= 1'b1;
        end else if (do_append) begin
          frame_count    <= count_app;
          frame_overflow <= ovf_app;
        end
      end
    end
  end

  // Frame store write: an opening delimiter lands at entry zero
  always_comb begin
    mem_we    = cmd.accept && (do_open || (do_append && has_room));
    mem_waddr = do_open ? '0 : frame_count[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_store[mem_waddr] <= in_byte;
    end
    if (cmd.fetch) begin
      rd_data <= frame_store[rd_ptr];
    end
  end

  // Burst pointers: start past the opening delimiter when stripping
  always_ff @(posedge clk) begin
    if (cmd.accept && stat.burst) begin
      rd_ptr    <= include_delims ? '0 : ADDR_W'(1);
      remaining <= emit_len;
      burst_len <= emit_len;
    end else if (cmd.load) begin
      rd_ptr    <= rd_ptr + ADDR_W'(1);
      remaining <= remaining - LEN_W'(1);
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_valid <= 1'b0;
    end else if (cmd.load || (cmd.accept && status_result)) begin
      tx_valid <= 1'b1;
    end else if (tx_ready) begin
      tx_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      data_byte  <= rd_data;
      byte_valid <= 1'b1;
      run_last   <= stat.last_byte;
      status     <= ST_OK;
      msg_length <= burst_len;
    end else if (cmd.accept && status_result) begin
      data_byte  <= '0;
      byte_valid <= 1'b0;
      run_last   <= 1'b1;
      status     <= status_code;
      msg_length <= '0;
    end
  end

endmodule

FILE: src/delimited_message_extractor_core.sv
// ----------------------------------------------------------------------------
// Delimited message extractor
// Extracts the first start/end delimited message from each received buffer.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while the block scans a buffer and the output
// register is free; a byte that causes a status-only result (stray footer,
// frame too large, empty stripped frame, unresolved end of buffer) does not
// end the scan. A frame that closes with bytes to emit stops the input while
// it drains: each emitted byte is read through the registered read port of
// the 64-entry frame store and then loaded into the output register, which
// waits while the result side stalls. The frame store needs no clearing
// after reset; only entries written for the current frame are read.
// Registers are to be written through the cfg port only while no buffer is
// in flight; the block itself does not enforce this.
module delimited_message_extractor_core (
  input  logic                           clk,
  input  logic                           rst,
  dme_in_if.sink                         rx,
  dme_out_if.source                      tx,
  input  logic                           cfg_wr_en,
  input  logic [dme_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dme_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dme_pkg::*;

  dme_cmd_t  cmd;
  dme_stat_t stat;

  // Sequencing
  dme_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx.valid),
    .rx_ready (rx.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Frame tracking, store and output register
  dme_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_byte       (rx.in_byte),
    .end_of_buffer (rx.end_of_buffer),
    .cmd           (cmd),
    .stat          (stat),
    .tx_ready      (tx.ready),
    .tx_valid      (tx.valid),
    .data_byte     (tx.data_byte),
    .byte_valid    (tx.byte_valid),
    .run_last      (tx.run_last),
    .status        (tx.status),
    .msg_length    (tx.msg_length)
  );

`ifndef SYNTH
  // Never take a byte while a result is stuck in the output register
  a_no_rx_over_pending: assert property (@(posedge clk) disable iff (rst)
    (rx.valid && rx.ready) |-> (!tx.valid || tx.ready))
    else $error("input transfer while output register is blocked");

  // Status-only results close the run and carry no length
  a_status_only_shape: assert property (@(posedge clk) disable iff (rst)
    (tx.valid && !tx.byte_valid) |-> (tx.run_last && (tx.msg_length == '0)))
    else $error("status-only result malformed");

  // Message bytes are always ok with a nonzero length
  a_data_shape: assert property (@(posedge clk) disable iff (rst)
    (tx.valid && tx.byte_valid) |-> ((tx.status == ST_OK) && (tx.msg_length != '0)))
    else $error("message byte with bad status or length");

  // Hold the input while a non-final message byte waits in the output register
  a_burst_holds_input: assert property (@(posedge clk) disable iff (rst)
    (tx.valid && tx.byte_valid && !tx.run_last) |-> !rx.ready)
    else $error("input taken in the middle of a burst");
`endif

endmodule

FILE: bench/tb_delimited_message_extractor_core.sv
// ----------------------------------------------------------------------------
// Delimited message extractor testbench
// Sends whole receive buffers, one byte per transfer, and predicts every
// result from a behavioral copy of the frame extraction rules. Results are
// compared field by field in order. The run steps through several register
// settings, with random gaps on both channels in all phases but one.
// ----------------------------------------------------------------------------
module tb_delimited_message_extractor_core;
  timeunit 1ns;
  timeprecision 1ps;
  import dme_pkg::*;

  localparam int CLK_PERIOD    = 20;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 16;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              vld;
    logic              last;
    dme_status_t       status;
    logic [LEN_W-1:0]  len;
  } msg_result_t;

  // Frame extraction predictor and in-order result checker
  class extract_scoreboard;
    logic [BYTE_W-1:0] start_delim;
    logic [BYTE_W-1:0] end_delim;
    logic [LEN_W-1:0]  max_size;
    logic              incl;
    logic [BYTE_W-1:0] frame_bytes[FRAME_DEPTH];
    int                frame_len;
    bit                in_frame;
    bit                overflowed;
    bit                ignoring;
    msg_result_t       due_results[$];
    int                errors;
    int                results_checked;

    function new();
      start_delim     = START_DELIM_RST;
      end_delim       = END_DELIM_RST;
      max_size        = MAX_MSG_SIZE_RST;
      incl            = INCLUDE_DELIMS_RST;
      frame_len       = 0;
      in_frame        = 0;
      overflowed      = 0;
      ignoring        = 0;
      errors          = 0;
      results_checked = 0;
    endfunction

    function void set_reg(dme_cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_START_DELIM:    start_delim = v;
        CFG_END_DELIM:      end_delim = v;
        CFG_MAX_MSG_SIZE:   max_size = v[LEN_W-1:0];
        CFG_INCLUDE_DELIMS: incl = v[0];
        default: ;
      endcase
    endfunction

    function void push(logic [BYTE_W-1:0] d, logic vld, logic last, dme_status_t st, int len);
      msg_result_t r;
      r.data   = d;
      r.vld    = vld;
      r.last   = last;
      r.status = st;
      r.len    = LEN_W'(len);
      due_results.push_back(r);
    endfunction

    function void store(logic [BYTE_W-1:0] b);
      if (frame_len < FRAME_DEPTH) begin
        frame_bytes[frame_len] = b;
        frame_len++;
      end else begin
        overflowed = 1;
      end
    endfunction

    // Close the open frame: too large, empty, or a run of message bytes
    function void close_frame();
      int first;
      int len;
      ignoring = 1;
      if (overflowed || frame_len >= int'(max_size)) begin
        push(8'h00, 1'b0, 1'b1, ST_TOO_LARGE, 0);
        return;
      end
      first = incl ? 0 : 1;
      len   = incl ? frame_len : (frame_len >= 2 ? frame_len - 2 : 0);
      if (len == 0) begin
        push(8'h00, 1'b0, 1'b1, ST_OK, 0);
        return;
      end
      for (int i = 0; i < len; i++) begin
        push(frame_bytes[first + i], 1'b1, i == len - 1, ST_OK, len);
      end
    endfunction

    // Advance the predictor by one accepted byte
    function void take_byte(logic [BYTE_W-1:0] b, logic eob);
      if (!ignoring) begin
        if (b == start_delim) begin
          if (start_delim == end_delim && in_frame) begin
            store(b);
            close_frame();
          end else begin
            in_frame   = 1;
            frame_len  = 0;
            overflowed = 0;
            store(b);
          end
        end else if (b == end_delim) begin
          if (in_frame) begin
            store(b);
            close_frame();
          end else begin
            push(8'h00, 1'b0, 1'b1, ST_FOOTER_NO_HEADER, 0);
            ignoring = 1;
          end
        end else if (in_frame) begin
          store(b);
        end
      end
      if (eob) begin
        if (!ignoring) begin
          push(8'h00, 1'b0, 1'b1, in_frame ? ST_HEADER_NO_FOOTER : ST_NO_DELIMS, 0);
        end
        frame_len  = 0;
        in_frame   = 0;
        overflowed = 0;
        ignoring   = 0;
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) begin
        $display("[%0t] MISMATCH: %s", $time, msg);
      end
    endtask

    task check_field(string name, logic [BYTE_W-1:0] got, logic [BYTE_W-1:0] want);
      if (got !== want) begin
        report($sformatf("result %0d %s: got %0h, want %0h", results_checked, name, got, want));
      end
    endtask

    task check_result(msg_result_t got);
      msg_result_t want;
      if (due_results.size() == 0) begin
        report($sformatf("unexpected result data %0h status %0d", got.data, got.status));
        return;
      end
      want = due_results.pop_front();
      results_checked++;
      check_field("data_byte", got.data, want.data);
      check_field("byte_valid", 8'(got.vld), 8'(want.vld));
      check_field("run_last", 8'(got.last), 8'(want.last));
      check_field("status", 8'(got.status), 8'(want.status));
      check_field("msg_length", 8'(got.len), 8'(want.len));
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    stall_en;
  int                    cycles = 0;
  int                    bytes_sent = 0;
  int                    buffers_sent = 0;
  int                    settings_used = 1;
  extract_scoreboard     sb;

  dme_in_if  rx_ch ();
  dme_out_if tx_ch ();

  delimited_message_extractor_core dut (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx_ch),
    .tx        (tx_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles,
               sb.due_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Observe transfers on both channels
  always @(posedge clk) begin : observe
    msg_result_t got;
    if (!rst) begin
      if (rx_ch.valid && rx_ch.ready) begin
        sb.take_byte(rx_ch.in_byte, rx_ch.end_of_buffer);
      end
      if (tx_ch.valid && tx_ch.ready) begin
        got.data   = tx_ch.data_byte;
        got.vld    = tx_ch.byte_valid;
        got.last   = tx_ch.run_last;
        got.status = dme_status_t'(tx_ch.status);
        got.len    = tx_ch.msg_length;
        sb.check_result(got);
      end
    end
  end

  // Stall the result channel at random
  initial begin
    tx_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      tx_ch.ready <= !(stall_en && $urandom_range(99) < 12);
      @(negedge clk);
    end
  end

  // Offer one byte and hold it until the transfer
  task automatic send_byte(logic [BYTE_W-1:0] b, logic eob);
    @(negedge clk);
    while (stall_en && $urandom_range(99) < 12) begin
      rx_ch.valid <= 1'b0;
      @(negedge clk);
    end
    rx_ch.valid         <= 1'b1;
    rx_ch.in_byte       <= b;
    rx_ch.end_of_buffer <= eob;
    do @(posedge clk); while (!rx_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_buffer(logic [BYTE_W-1:0] q[$]);
    for (int i = 0; i < q.size(); i++) begin
      send_byte(q[i], i == q.size() - 1);
    end
    buffers_sent++;
  endtask

  // Drop valid and wait until every predicted result has arrived
  task automatic settle();
    @(negedge clk);
    rx_ch.valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(dme_cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic configure(logic [7:0] s, logic [7:0] e, logic [7:0] m, logic inc);
    write_reg(CFG_START_DELIM, s);
    write_reg(CFG_END_DELIM, e);
    write_reg(CFG_MAX_MSG_SIZE, m);
    write_reg(CFG_INCLUDE_DELIMS, {7'd0, inc});
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  // Random byte that is neither delimiter
  function automatic logic [7:0] filler();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == sb.start_delim || b == sb.end_delim);
    return b;
  endfunction

  // Mostly framed buffers with random content, the rest delimiter noise
  task automatic send_random_buffer(int max_body);
    logic [7:0] frame_q[$];
    int         n;
    if ($urandom_range(9) < 7) begin
      n = $urandom_range(3);
      repeat (n) frame_q.push_back(filler());
      frame_q.push_back(sb.start_delim);
      n = ($urandom_range(7) == 0) ? $urandom_range(max_body)
                                   : $urandom_range(max_body < 6 ? max_body : 6);
      for (int i = 0; i < n; i++) begin
        if (sb.start_delim != sb.end_delim && $urandom_range(9) == 0) begin
          frame_q.push_back(sb.start_delim);
        end else begin
          frame_q.push_back(filler());
        end
      end
      frame_q.push_back(sb.end_delim);
      n = $urandom_range(3);
      repeat (n) frame_q.push_back(8'($urandom_range(255)));
    end else begin
      n = $urandom_range(1, 8);
      repeat (n) begin
        case ($urandom_range(3))
          0:       frame_q.push_back(sb.start_delim);
          1:       frame_q.push_back(sb.end_delim);
          default: frame_q.push_back(8'($urandom_range(255)));
        endcase
      end
    end
    send_buffer(frame_q);
  endtask

  task automatic random_phase(int count, int max_body);
    repeat (count) send_random_buffer(max_body);
    settle();
  endtask

  initial begin
    logic [7:0] long_q[$];
    rst                 = 1'b1;
    rx_ch.valid         = 1'b0;
    rx_ch.in_byte       = '0;
    rx_ch.end_of_buffer = 1'b0;
    cfg_wr_en           = 1'b0;
    cfg_index           = CFG_START_DELIM;
    cfg_data            = '0;
    stall_en            = 1'b1;
    sb                  = new();
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed: reset settings, missing delimiters, stray footer, restart
    send_buffer('{8'h00});
    send_buffer('{8'hFF});
    send_buffer('{END_DELIM_RST, 8'h41});
    send_buffer('{START_DELIM_RST, 8'h55, 8'hAA});
    send_buffer('{8'h11, START_DELIM_RST, 8'h01, START_DELIM_RST, 8'h02,
                  END_DELIM_RST, 8'h99});
    settle();

    // Directed: stripped delimiters, empty message closing on the last byte
    configure(START_DELIM_RST, END_DELIM_RST, 8'd65, 1'b0);
    send_buffer('{START_DELIM_RST, END_DELIM_RST});
    send_buffer('{START_DELIM_RST, 8'h80, 8'h7F, END_DELIM_RST});
    settle();

    // Directed: equal delimiters with a tight size limit
    configure(8'h7E, 8'h7E, 8'd3, 1'b0);
    send_buffer('{8'h7E, 8'h01, 8'h7E});
    send_buffer('{8'h7E, 8'h7E});
    send_buffer('{8'h7E, 8'h5A, 8'h7E, 8'h7E});
    settle();

    // Random phases across register settings
    configure(START_DELIM_RST, END_DELIM_RST, 8'd65, 1'b1);
    random_phase(2, 20);
    configure(8'h00, 8'hFF, 8'd20, 1'b0);
    random_phase(2, 20);
    configure(8'hFF, 8'h00, 8'd1, 1'b1);
    random_phase(1, 6);

    // Run one phase with both channels free of gaps
    stall_en = 1'b0;
    configure(8'h2A, 8'h2A, 8'd65, 1'b1);
    random_phase(3, 20);
    stall_en = 1'b1;

    configure(8'h55, 8'hAA, 8'd0, 1'b0);
    random_phase(1, 6);

    // Full-depth frame, then one that overflows the store
    configure(8'h10, 8'h20, 8'd127, 1'b1);
    long_q.push_back(8'h10);
    repeat (FRAME_DEPTH - 2) long_q.push_back(filler());
    long_q.push_back(8'h20);
    send_buffer(long_q);
    long_q.delete();
    long_q.push_back(8'h10);
    repeat (FRAME_DEPTH + 1) long_q.push_back(filler());
    long_q.push_back(8'h20);
    long_q.push_back(8'h33);
    send_buffer(long_q);
    random_phase(1, 10);

    configure(8'hFF, 8'hFF, 8'd40, 1'b0);
    random_phase(1, 20);

    $display("Sent %0d bytes in %0d buffers over %0d register settings.",
             bytes_sent, buffers_sent, settings_used);
    $display("Compared %0d results, %0d mismatches.", sb.results_checked, sb.errors);
    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
src/dme_pkg.sv
src/dme_if.sv
src/dme_ctrl.sv
src/dme_datapath.sv
src/delimited_message_extractor_core.sv
bench/tb_delimited_message_extractor_core.sv
